/* rtl/core/i2ccrc_pkg.sv */
// i2ccrc_pkg: types, constants and the CRC-8 byte update shared by the
// i2c crc8 frame checker, its result queue and its checker.
// no dependencies.
`timescale 1ns / 1ps

package i2ccrc_pkg;

  localparam int ADDR_W = 7;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLYNOMIAL = 1'b1;

  localparam logic [ADDR_W-1:0] ADDR_RESET = 7'd8;
  localparam logic [BYTE_W-1:0] POLY_RESET = 8'h07;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic RW_READ_BIT = 1'b1;
  localparam logic RW_WRITE_BIT = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_crc;
    logic              crc_ok;
    logic              frame_error;
    logic              end_of_run;
  } res_t;

  // msb-first crc-8 update of one byte, eight shift/xor steps
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data,
                                                  input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] crc;
    logic              fb;
    crc = crc_in;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb  = crc[BYTE_W-1] ^ data[i];
      crc = {crc[BYTE_W-2:0], 1'b0} ^ (fb ? poly : '0);
    end
    return crc;
  endfunction

endpackage

/* rtl/core/i2ccrc_if.sv */
// i2ccrc_in_if / i2ccrc_out_if: valid/ready channels of the frame checker.
// depends on i2ccrc_pkg for widths.
`timescale 1ns / 1ps

interface i2ccrc_in_if import i2ccrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] frame_byte;
  logic              first_of_frame;
  logic              last_of_frame;

  modport source (output valid, kind, frame_byte, first_of_frame, last_of_frame,
                  input ready);
  modport sink (input valid, kind, frame_byte, first_of_frame, last_of_frame,
                output ready);
endinterface

interface i2ccrc_out_if import i2ccrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_crc;
  logic              crc_ok;
  logic              frame_error;
  logic              end_of_run;

  modport source (output valid, out_byte, is_crc, crc_ok, frame_error, end_of_run,
                  input ready);
  modport sink (input valid, out_byte, is_crc, crc_ok, frame_error, end_of_run,
                output ready);
endinterface

/* rtl/core/i2ccrc_result_fifo.sv */
// i2ccrc_result_fifo: small result queue, up to two beats in and one out
// per cycle. depends on i2ccrc_pkg (res_t).
`timescale 1ns / 1ps

module i2ccrc_result_fifo import i2ccrc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_a,
  input  res_t data_a,
  input  logic push_b,
  input  res_t data_b,
  output logic space_ok,
  input  logic pop,
  output logic not_empty,
  output res_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_b_ptr;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;
  assign space_ok  = (count_r <= CW'(DEPTH - 2));
  assign wr_b_ptr  = push_a ? wrap_inc(wr_ptr_r) : wr_ptr_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_a && push_b) begin
      wr_ptr_nxt = wrap_inc(wrap_inc(wr_ptr_r));
    end else if (push_a || push_b) begin
      wr_ptr_nxt = wrap_inc(wr_ptr_r);
    end
    rd_ptr_nxt = do_pop ? wrap_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_a) + CW'(push_b) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wr_ptr_r] <= data_a;
    end
    if (push_b) begin
      mem_r[wr_b_ptr] <= data_b;
    end
  end

endmodule

/* rtl/core/i2c_crc8_frame_checker.sv */
// i2c_crc8_frame_checker: crc-8 check of read responses and crc generation
// for write frames. results are pushed into a registered queue on acceptance.
// throughput: one byte per cycle while the queue has space; a last write
// byte gives two beats, so the output port sets the pace (queue of FIFO_DEPTH).
// reset (synchronous, rst_n low): registers back to address 8, polynomial 0x07,
// crc state cleared, next byte starts a frame, result queue empty.
`timescale 1ns / 1ps

module i2c_crc8_frame_checker import i2ccrc_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  i2ccrc_in_if.sink             in_if,
  i2ccrc_out_if.source          out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [BYTE_W-1:0] poly_r, poly_nxt;
  logic [BYTE_W-1:0] rd_addr_crc_r, wr_addr_crc_r;

  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic              exp_crc_r, exp_crc_nxt;
  logic              fpp_r, fpp_nxt;
  logic              sticky_r, sticky_nxt;

  logic              accept;
  logic              fpp_eff, exp_eff;
  logic              crc_match;
  logic [BYTE_W-1:0] crc_base, crc_new;
  logic              push_a, push_b, space_ok, not_empty;
  res_t              res_a, res_b, head;

  // config registers; the address crc follows at the same edge
  always_comb begin
    addr_nxt = addr_r;
    poly_nxt = poly_r;
    if (!rst_n) begin
      addr_nxt = ADDR_RESET;
      poly_nxt = POLY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: addr_nxt = cfg_wdata[ADDR_W-1:0];
        CFG_CRC_POLYNOMIAL: poly_nxt = cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
      poly_r <= POLY_RESET;
    end else begin
      addr_r <= addr_nxt;
      poly_r <= poly_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_crc_r <= crc8_byte('0, {addr_nxt, RW_READ_BIT}, poly_nxt);
    wr_addr_crc_r <= crc8_byte('0, {addr_nxt, RW_WRITE_BIT}, poly_nxt);
  end

  assign accept    = in_if.valid && in_if.ready;
  assign in_if.ready = space_ok;

  assign fpp_eff   = in_if.first_of_frame || fpp_r;
  assign exp_eff   = !in_if.first_of_frame && exp_crc_r;
  assign crc_match = (in_if.frame_byte == acc_r);

  // one crc step per byte: the address byte is folded in ahead of time
  always_comb begin
    if (in_if.kind == KIND_READ) begin
      crc_base = fpp_eff ? rd_addr_crc_r : '0;
    end else begin
      crc_base = fpp_eff ? wr_addr_crc_r : acc_r;
    end
  end

  assign crc_new = crc8_byte(crc_base, in_if.frame_byte, poly_r);

  always_comb begin
    acc_nxt     = acc_r;
    held_nxt    = held_r;
    exp_crc_nxt = exp_crc_r;
    fpp_nxt     = fpp_r;
    sticky_nxt  = sticky_r;
    push_a      = 1'b0;
    push_b      = 1'b0;
    res_a       = '0;
    res_b       = '0;
    if (accept) begin
      if (in_if.kind == KIND_READ) begin
        if (!exp_eff) begin
          // data byte of a pair
          acc_nxt    = crc_new;
          held_nxt   = in_if.frame_byte;
          sticky_nxt = fpp_eff ? 1'b0 : sticky_r;
          if (in_if.last_of_frame) begin
            // frame ends without its crc byte
            sticky_nxt  = 1'b1;
            exp_crc_nxt = 1'b0;
            fpp_nxt     = 1'b1;
            push_a      = 1'b1;
            res_a       = '{out_byte: in_if.frame_byte, is_crc: 1'b0, crc_ok: 1'b0,
                            frame_error: 1'b1, end_of_run: 1'b1};
          end else begin
            exp_crc_nxt = 1'b1;
            fpp_nxt     = 1'b0;
          end
        end else begin
          sticky_nxt  = sticky_r || !crc_match;
          exp_crc_nxt = 1'b0;
          fpp_nxt     = in_if.last_of_frame;
          push_a      = 1'b1;
          res_a       = '{out_byte: held_r, is_crc: 1'b0, crc_ok: crc_match,
                          frame_error: sticky_r || !crc_match,
                          end_of_run: in_if.last_of_frame};
        end
      end else begin
        acc_nxt     = crc_new;
        held_nxt    = in_if.frame_byte;
        exp_crc_nxt = 1'b0;
        fpp_nxt     = in_if.last_of_frame;
        push_a      = 1'b1;
        res_a       = '{out_byte: in_if.frame_byte, is_crc: 1'b0, crc_ok: 1'b0,
                        frame_error: 1'b0, end_of_run: 1'b0};
        push_b      = in_if.last_of_frame;
        res_b       = '{out_byte: crc_new, is_crc: 1'b1, crc_ok: 1'b0,
                        frame_error: 1'b0, end_of_run: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      held_r    <= '0;
      exp_crc_r <= 1'b0;
      fpp_r     <= 1'b1;
      sticky_r  <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      held_r    <= held_nxt;
      exp_crc_r <= exp_crc_nxt;
      fpp_r     <= fpp_nxt;
      sticky_r  <= sticky_nxt;
    end
  end

  i2ccrc_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (push_a),
    .data_a    (res_a),
    .push_b    (push_b),
    .data_b    (res_b),
    .space_ok  (space_ok),
    .pop       (out_if.ready),
    .not_empty (not_empty),
    .head      (head)
  );

  assign out_if.valid       = not_empty;
  assign out_if.out_byte    = head.out_byte;
  assign out_if.is_crc      = head.is_crc;
  assign out_if.crc_ok      = head.crc_ok;
  assign out_if.frame_error = head.frame_error;
  assign out_if.end_of_run  = head.end_of_run;

endmodule

/* rtl/core/i2ccrc_checker.sv */
// i2ccrc_checker: port-level assertions for i2c_crc8_frame_checker, attached
// by bind. depends on i2ccrc_pkg.
`timescale 1ns / 1ps

module i2ccrc_checker import i2ccrc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_kind,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_is_crc,
  input logic              out_crc_ok,
  input logic              out_frame_error,
  input logic              out_end_of_run
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat offered right after reset");

  // a generated crc always closes the frame, with pass and error flags low
  a_crc_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_crc |-> out_end_of_run && !out_crc_ok && !out_frame_error)
    else $error("write crc beat with wrong flags");

  // a pass flag never comes on a generated crc beat
  a_ok_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crc_ok |-> !out_is_crc)
    else $error("crc_ok on a generated crc beat");

  // last write byte leaves results waiting on the next cycle
  a_write_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_WRITE) && in_last |=> out_valid)
    else $error("no result after last write byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled result beat changed");

endmodule

bind i2c_crc8_frame_checker i2ccrc_checker u_i2ccrc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_kind         (in_if.kind),
  .in_last         (in_if.last_of_frame),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_byte        (out_if.out_byte),
  .out_is_crc      (out_if.is_crc),
  .out_crc_ok      (out_if.crc_ok),
  .out_frame_error (out_if.frame_error),
  .out_end_of_run  (out_if.end_of_run)
);
